// ===== rtl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string escape encoder package
// Shared command type, character codes and the hex digit helper.
// ----------------------------------------------------------------------------
package jse_pkg;

	// Kind of output text that one queued command expands to.
	typedef enum logic [1:0] {
		CMD_CHAR = 2'd0,	// one byte, passed through
		CMD_PAIR = 2'd1,	// backslash and one character
		CMD_UESC = 2'd2		// backslash, 'u' and four hex digits
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] code;
	} cmd_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_HT = 8'h09;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_CR = 8'h0D;

	// Index of the final byte of the pair and u-escape command kinds.
	localparam logic [2:0] PAIR_LAST_IDX = 3'd1;
	localparam logic [2:0] UESC_LAST_IDX = 3'd5;

	// Uppercase hex digit in ASCII.
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 4'd10) begin
			hex_digit = {4'h0, v} + 8'd48;
		end else begin
			hex_digit = {4'h0, v} + 8'd55;
		end
	endfunction

endpackage

// ===== rtl/jse_raw_if.sv =====
// ----------------------------------------------------------------------------
// Raw byte channel
// Carries one raw string byte and its end flag per item.
// ----------------------------------------------------------------------------
interface jse_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== rtl/jse_esc_if.sv =====
// ----------------------------------------------------------------------------
// Escaped byte channel
// Carries one byte of escaped text and the last-of-run flag per item.
// ----------------------------------------------------------------------------
interface jse_esc_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/jse_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Classifies raw bytes, collects UTF-8 sequences and issues text commands.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	jse_raw_if.sink      raw,
	output logic         push_valid,
	input  logic         push_ready,
	output cmd_t         push_data
);

	logic [1:0]  pending_q;
	logic        skipping_q;
	logic [15:0] accum_q;

	logic [1:0]  pending_d;
	logic        skipping_d;
	logic [15:0] accum_d;
	logic [1:0]  pending_dec;
	logic [15:0] cont_bits;
	logic        has_cmd;
	logic        accept;
	cmd_t        cmd;

	assign raw.ready = push_ready;
	assign accept    = raw.valid && push_ready;

	assign pending_dec = pending_q - 2'd1;

	always_comb begin
		case (pending_dec)
			2'd0:    cont_bits = {10'd0, raw.in_byte[5:0]};
			2'd1:    cont_bits = {4'd0, raw.in_byte[5:0], 6'd0};
			default: cont_bits = {raw.in_byte[3:0], 12'd0};
		endcase
	end

	always_comb begin
		pending_d  = pending_q;
		skipping_d = skipping_q;
		accum_d    = accum_q;
		has_cmd    = 1'b0;
		cmd.kind   = CMD_CHAR;
		cmd.code   = {8'd0, raw.in_byte};
		if (pending_q != 2'd0) begin
			pending_d = pending_dec;
			if (!skipping_q) begin
				accum_d = accum_q | cont_bits;
				if (pending_dec == 2'd0) begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_UESC;
					cmd.code = accum_q | cont_bits;
				end
			end
			if (pending_dec == 2'd0) begin
				skipping_d = 1'b0;
				accum_d    = 16'd0;
			end
		end else begin
			case (raw.in_byte) inside
				CH_QUOTE, CH_BSLASH, CH_SLASH: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_PAIR;
				end
				CTL_BS: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_PAIR;
					cmd.code = {8'd0, CH_LOW_B};
				end
				CTL_FF: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_PAIR;
					cmd.code = {8'd0, CH_LOW_F};
				end
				CTL_LF: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_PAIR;
					cmd.code = {8'd0, CH_LOW_N};
				end
				CTL_CR: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_PAIR;
					cmd.code = {8'd0, CH_LOW_R};
				end
				CTL_HT: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_PAIR;
					cmd.code = {8'd0, CH_LOW_T};
				end
				[8'h00:8'h1F]: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_UESC;
				end
				[8'h20:8'h7F]: begin
					has_cmd  = 1'b1;
					cmd.kind = CMD_CHAR;
				end
				[8'hC0:8'hDF]: begin
					accum_d   = {5'd0, raw.in_byte[4:0], 6'd0};
					pending_d = 2'd1;
				end
				[8'hE0:8'hEF]: begin
					accum_d   = {raw.in_byte[3:0], 12'd0};
					pending_d = 2'd2;
				end
				[8'hF0:8'hF7]: begin
					skipping_d = 1'b1;
					pending_d  = 2'd3;
				end
				default: begin
					// Stray continuation bytes and F8 to FF are dropped.
				end
			endcase
		end
		if (raw.end_of_string) begin
			pending_d  = 2'd0;
			skipping_d = 1'b0;
			accum_d    = 16'd0;
		end
	end

	assign push_valid = raw.valid && has_cmd;
	assign push_data  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 2'd0;
			skipping_q <= 1'b0;
			accum_q    <= 16'd0;
		end else if (accept) begin
			pending_q  <= pending_d;
			skipping_q <= skipping_d;
			accum_q    <= accum_d;
		end
	end

endmodule

// ===== rtl/jse_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module jse_queue import jse_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			next_ptr = '0;
		end else begin
			next_ptr = p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/jse_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Expands queued commands into escaped text, one byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  cmd_t         pop_data,
	jse_esc_if.source    esc
);

	logic        busy_q;
	cmd_kind_t   kind_q;
	logic [15:0] code_q;
	logic [2:0]  idx_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;

	logic        advance;
	logic        at_last;
	logic [7:0]  cur_byte;

	assign advance = busy_q && (!out_valid_q || esc.ready);

	always_comb begin
		case (kind_q)
			CMD_CHAR: begin
				at_last  = 1'b1;
				cur_byte = code_q[7:0];
			end
			CMD_PAIR: begin
				at_last  = (idx_q == PAIR_LAST_IDX);
				cur_byte = (idx_q == 3'd0) ? CH_BSLASH : code_q[7:0];
			end
			CMD_UESC: begin
				at_last = (idx_q == UESC_LAST_IDX);
				case (idx_q)
					3'd0:    cur_byte = CH_BSLASH;
					3'd1:    cur_byte = CH_LOW_U;
					3'd2:    cur_byte = hex_digit(code_q[15:12]);
					3'd3:    cur_byte = hex_digit(code_q[11:8]);
					3'd4:    cur_byte = hex_digit(code_q[7:4]);
					default: cur_byte = hex_digit(code_q[3:0]);
				endcase
			end
			default: begin
				at_last  = 1'b1;
				cur_byte = code_q[7:0];
			end
		endcase
	end

	assign pop_ready = !busy_q || (advance && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= CMD_CHAR;
			idx_q  <= 3'd0;
		end else if (pop_valid && pop_ready) begin
			busy_q <= 1'b1;
			kind_q <= pop_data.kind;
			idx_q  <= 3'd0;
		end else if (advance && at_last) begin
			busy_q <= 1'b0;
		end else if (advance) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			code_q <= pop_data.code;
		end
		if (advance) begin
			out_byte_q <= cur_byte;
			run_last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (esc.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign esc.valid    = out_valid_q;
	assign esc.out_byte = out_byte_q;
	assign esc.run_last = run_last_q;

endmodule

// ===== rtl/json_string_escape_encoder.sv =====
// Path: an item goes from the queue into the back end and out through its output register.
// Throughput: the front end takes one item per cycle while the command queue has room;
// the back end sends one byte per cycle while esc is ready; an item is 0, 1, 2 or 6 bytes.
// The output port is the bottleneck: a control byte without a short escape, or the byte that
// completes a UTF-8 sequence, yields six bytes; lead and dropped bytes yield none.
// Reset: arst_n clears the UTF-8 collector, the queue and the output register at once.
// ----------------------------------------------------------------------------
// JSON string escape encoder
// Turns raw string bytes into JSON-escaped text, one byte per output item.
// ----------------------------------------------------------------------------
module json_string_escape_encoder import jse_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	jse_raw_if.sink    raw,
	jse_esc_if.source  esc
);

	// The front end decides what text each raw byte produces and keeps the
	// UTF-8 collector state. Bytes that produce no text (leads, dropped bytes)
	// are accepted without touching the queue.
	logic push_valid;
	logic push_ready;
	cmd_t push_data;

	// The queue decouples classification from expansion, so a new raw item can
	// be taken while a six-byte escape is still going out.
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw        (raw),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back end walks each command byte by byte into a registered output
	// stage, which keeps the result stable while the downstream side stalls.
	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.esc       (esc)
	);

endmodule

// ===== tb/sv/jse_escape_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON escape scoreboard
// Watches both channels of the encoder. It predicts the escaped text of every
// accepted raw byte and compares each escaped byte with the oldest prediction.
// ----------------------------------------------------------------------------
module jse_escape_checker import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       raw_valid,
	input  logic       raw_ready,
	input  logic [7:0] raw_byte,
	input  logic       raw_eos,
	input  logic       esc_valid,
	input  logic       esc_ready,
	input  logic [7:0] esc_byte,
	input  logic       esc_last,
	output int         mismatch_count,
	output int         expected_count
);

	localparam int REPORT_LIMIT = 10;

	// Lead byte patterns of UTF-8 sequences, as mask and match pairs.
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_MATCH = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_MATCH = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_MATCH = 8'hF0;
	localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
	localparam logic [7:0] FIRST_HIGH      = 8'h80;

	typedef struct packed {
		logic [7:0] text;
		logic       run_last;
	} esc_char_t;

	esc_char_t   escaped_text_q[$];
	logic [1:0]  cont_left;
	logic        drop_seq;
	logic [15:0] code_point;
	int          result_index;

	function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
		return (nib < 4'd10) ? 8'd48 + 8'(nib) : 8'd55 + 8'(nib);
	endfunction

	function automatic void push_char(input logic [7:0] c);
		escaped_text_q.push_back('{text: c, run_last: 1'b0});
	endfunction

	function automatic void push_u_escape(input logic [15:0] code);
		push_char(CH_BSLASH);
		push_char(CH_LOW_U);
		push_char(hex_ascii(code[15:12]));
		push_char(hex_ascii(code[11:8]));
		push_char(hex_ascii(code[7:4]));
		push_char(hex_ascii(code[3:0]));
	endfunction

	function automatic void encode_byte(input logic [7:0] b, input logic eos);
		int base;
		base = escaped_text_q.size();
		if (cont_left != 2'd0) begin
			// Any byte counts as a continuation here; only its low six bits are used.
			cont_left = cont_left - 2'd1;
			if (!drop_seq) begin
				code_point = code_point | (16'(b[5:0]) << (6 * cont_left));
				if (cont_left == 2'd0) begin
					push_u_escape(code_point);
				end
			end
			if (cont_left == 2'd0) begin
				drop_seq = 1'b0;
				code_point = 16'd0;
			end
		end else if (b < FIRST_PRINTABLE || b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH) begin
			case (b)
				CH_QUOTE, CH_BSLASH, CH_SLASH: begin
					push_char(CH_BSLASH);
					push_char(b);
				end
				CTL_BS: begin
					push_char(CH_BSLASH);
					push_char(CH_LOW_B);
				end
				CTL_FF: begin
					push_char(CH_BSLASH);
					push_char(CH_LOW_F);
				end
				CTL_LF: begin
					push_char(CH_BSLASH);
					push_char(CH_LOW_N);
				end
				CTL_CR: begin
					push_char(CH_BSLASH);
					push_char(CH_LOW_R);
				end
				CTL_HT: begin
					push_char(CH_BSLASH);
					push_char(CH_LOW_T);
				end
				default: begin
					push_u_escape(16'(b));
				end
			endcase
		end else if (b < FIRST_HIGH) begin
			push_char(b);
		end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
			code_point = 16'(b[4:0]) << 6;
			cont_left = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
			code_point = 16'(b[3:0]) << 12;
			cont_left = 2'd2;
		end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
			drop_seq = 1'b1;
			cont_left = 2'd3;
		end
		if (eos) begin
			cont_left = 2'd0;
			drop_seq = 1'b0;
			code_point = 16'd0;
		end
		if (escaped_text_q.size() > base) begin
			escaped_text_q[escaped_text_q.size() - 1].run_last = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		esc_char_t want;
		if (!arst_n) begin
			escaped_text_q.delete();
			cont_left = 2'd0;
			drop_seq = 1'b0;
			code_point = 16'd0;
			result_index = 0;
			mismatch_count = 0;
			expected_count = 0;
		end else begin
			if (raw_valid && raw_ready) begin
				encode_byte(raw_byte, raw_eos);
			end
			if (esc_valid && esc_ready) begin
				if (escaped_text_q.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$display("ERROR: escaped byte 0x%02h last %0b arrived with nothing expected",
							esc_byte, esc_last);
					end
					mismatch_count = mismatch_count + 1;
				end else begin
					want = escaped_text_q.pop_front();
					if (want.text !== esc_byte || want.run_last !== esc_last) begin
						if (mismatch_count < REPORT_LIMIT) begin
							$display("ERROR: escaped byte %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
								result_index, want.text, want.run_last, esc_byte, esc_last);
						end
						mismatch_count = mismatch_count + 1;
					end
				end
				result_index = result_index + 1;
			end
			expected_count = escaped_text_q.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escape encoder testbench
// Drives raw string bytes into the encoder under changing backpressure and
// lets the scoreboard check every escaped byte, then gives the verdict.
// ----------------------------------------------------------------------------
module tb import jse_pkg::*;;

	// The watchdog ends the run after this many cycles without any handshake.
	localparam int WATCHDOG_CYCLES = 2000;
	// The long receiver hold-off, long enough to fill the command queue.
	localparam int HOLD_CYCLES = 120;
	// Cycles waited after the last escaped byte; the first byte of an item shows up once it has
	// passed the queue and the back end, so this leaves a comfortable margin.
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS = 82;
	localparam int NUM_DIRECTED = 24;

	// Kinds of token that the random stimulus is built from.
	typedef enum int {
		TOK_PRINTABLE = 0,
		TOK_CONTROL   = 1,
		TOK_SPECIAL   = 2,
		TOK_UTF8_2    = 3,
		TOK_UTF8_3    = 4,
		TOK_UTF8_4    = 5,
		TOK_NOISE     = 6,
		TOK_BROKEN    = 7
	} token_kind_t;

	// Directed items, each the end flag above the byte. They cover the simple
	// escapes, control bytes with and without a short form, plain ASCII, a
	// three-byte sequence, a dropped four-byte sequence, a stray continuation,
	// a byte above F7, an end flag inside a sequence and a two-byte sequence
	// whose unchecked continuation carries the end flag.
	localparam logic [8:0] DIRECTED [NUM_DIRECTED] = '{
		9'h041, 9'h000, 9'h07F, 9'h022, 9'h05C, 9'h02F, 9'h008, 9'h00C,
		9'h00A, 9'h00D, 9'h009, 9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F,
		9'h098, 9'h080, 9'h080, 9'h0FF, 9'h0E2, 9'h182, 9'h0C3, 9'h141
	};

	logic clk;
	logic arst_n;

	int mismatch_count;
	int expected_count;
	int items_sent;
	int src_idle_pct;
	int snk_idle_pct;
	int hold_requests;
	int holds_done;
	int stall_cycles;

	jse_raw_if raw();
	jse_esc_if esc();

	json_string_escape_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.esc    (esc)
	);

	jse_escape_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.raw_valid      (raw.valid),
		.raw_ready      (raw.ready),
		.raw_byte       (raw.in_byte),
		.raw_eos        (raw.end_of_string),
		.esc_valid      (esc.valid),
		.esc_ready      (esc.ready),
		.esc_byte       (esc.out_byte),
		.esc_last       (esc.run_last),
		.mismatch_count (mismatch_count),
		.expected_count (expected_count)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Receiver. It changes ready at the falling edge, idling at the current
	// rate. When the stimulus asks for a hold-off it keeps ready low for a
	// fixed stretch that it counts itself, while the sender keeps offering.
	initial begin
		holds_done = 0;
		forever begin
			if (hold_requests > holds_done) begin
				repeat (HOLD_CYCLES) begin
					esc.ready <= 1'b0;
					@(negedge clk);
				end
				holds_done = holds_done + 1;
			end
			esc.ready <= ($urandom_range(99) >= snk_idle_pct);
			@(negedge clk);
		end
	end

	// Watchdog. A run in which nothing moves for too long has hung.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if (!arst_n || (raw.valid && raw.ready) || (esc.valid && esc.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles = stall_cycles + 1;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	// A continuation byte; now and then any byte at all, since the encoder
	// takes whatever comes while a sequence is open.
	function automatic logic [7:0] cont_byte();
		return ($urandom_range(7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
	endfunction

	// Offers one item, called at a falling edge. Random idle cycles come
	// first; the task returns at the falling edge after the item was taken
	// and leaves valid high so that back-to-back items need no gap.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < src_idle_pct) begin
			raw.valid <= 1'b0;
			raw.in_byte <= 8'($urandom);
			raw.end_of_string <= 1'($urandom);
			@(negedge clk);
		end
		raw.valid <= 1'b1;
		raw.in_byte <= b;
		raw.end_of_string <= eos;
		do begin
			@(posedge clk);
		end while (!raw.ready);
		items_sent = items_sent + 1;
		@(negedge clk);
	endtask

	// Stops offering and waits until every predicted byte has come out.
	task automatic pause_until_drained();
		raw.valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (expected_count != 0);
	endtask

	// Sends one random token. Most tokens are well-formed characters or
	// sequences; the rest are noise bytes and sequences cut short by the end
	// flag. Any token may close the string.
	task automatic send_token();
		int          pick;
		int          seq_len;
		int          conts;
		token_kind_t kind;
		logic        eos;
		logic [7:0]  lead;
		pick = $urandom_range(9);
		kind = (pick < 3) ? TOK_PRINTABLE : token_kind_t'(pick - 2);
		eos = ($urandom_range(11) == 0);
		case (kind)
			TOK_PRINTABLE: begin
				send_byte(8'($urandom_range(8'h7F, 8'h20)), eos);
			end
			TOK_CONTROL: begin
				send_byte(8'($urandom_range(8'h1F)), eos);
			end
			TOK_SPECIAL: begin
				case ($urandom_range(2))
					0: send_byte(CH_QUOTE, eos);
					1: send_byte(CH_BSLASH, eos);
					default: send_byte(CH_SLASH, eos);
				endcase
			end
			TOK_UTF8_2: begin
				send_byte({3'b110, 5'($urandom)}, 1'b0);
				send_byte(cont_byte(), eos);
			end
			TOK_UTF8_3: begin
				send_byte({4'b1110, 4'($urandom)}, 1'b0);
				send_byte(cont_byte(), 1'b0);
				send_byte(cont_byte(), eos);
			end
			TOK_UTF8_4: begin
				send_byte({5'b11110, 3'($urandom)}, 1'b0);
				send_byte(cont_byte(), 1'b0);
				send_byte(cont_byte(), 1'b0);
				send_byte(cont_byte(), eos);
			end
			TOK_NOISE: begin
				send_byte(8'($urandom), eos);
			end
			default: begin
				// A sequence that the end flag cuts off before it is complete.
				seq_len = $urandom_range(4, 2);
				case (seq_len)
					2: lead = {3'b110, 5'($urandom)};
					3: lead = {4'b1110, 4'($urandom)};
					default: lead = {5'b11110, 3'($urandom)};
				endcase
				conts = $urandom_range(seq_len - 2);
				send_byte(lead, conts == 0);
				for (int i = 1; i <= conts; i++) begin
					send_byte(cont_byte(), i == conts);
				end
			end
		endcase
	endtask

	// Stimulus and verdict.
	initial begin
		int target;
		arst_n = 1'b0;
		raw.valid = 1'b0;
		raw.in_byte = 8'd0;
		raw.end_of_string = 1'b0;
		items_sent = 0;
		hold_requests = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		end

		// Three random phases: a slow receiver, then a slow sender, then
		// neither idling. Each starts from an empty pipeline; the last starts
		// with the long hold-off so that the queue fills and input stalls.
		for (int phase = 0; phase < 3; phase++) begin
			pause_until_drained();
			case (phase)
				0: begin
					src_idle_pct = 18;
					snk_idle_pct = 85;
				end
				1: begin
					src_idle_pct = 85;
					snk_idle_pct = 18;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					hold_requests = hold_requests + 1;
				end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				send_token();
			end
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
